### design/esd_pkg.sv
// Shared types and character constants for the escape sequence decoder.
package esd_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UP_K  = 8'h4b;
    localparam logic [7:0] CH_UP_N  = 8'h4e;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_L  = 8'h6c;
    localparam logic [7:0] CH_LO_N  = 8'h6e;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CARET_MASK = 8'h1f;

    localparam int SLOTS = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_end;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       string_end;
    } slot_t;

    // All results caused by one input item, oldest in slot 0
    typedef struct packed {
        logic [1:0]            cnt;
        slot_t [SLOTS-1:0]     slots;
    } bundle_t;

endpackage

### design/esd_front.sv
// Front end: parses input bytes, tracks escape state, builds result bundles.
module esd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              in_fire,
    input  esd_pkg::in_item_t in_item,
    output logic              bundle_push,
    output esd_pkg::bundle_t  bundle
);

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_CARET  = 4'b0010,
        MODE_BSLASH = 4'b0100,
        MODE_OCTAL  = 4'b1000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] oval_reg, oval_next;
    logic       ovf_reg, ovf_next;
    logic       sup_reg, sup_next;
    logic       send_mode_reg;

    logic [7:0] c;
    logic       is_end;
    logic       c_octal;
    logic [2:0] c_digit;
    logic       fo_special;
    logic [7:0] fo_b0, fo_b1;
    logic [2:0] raw_vld;
    logic [7:0] raw_byte [3];
    logic       term;
    logic       sup;
    logic [1:0] kcnt;
    esd_pkg::bundle_t bnd;

    assign c       = in_item.in_byte;
    assign is_end  = in_item.kind || (c == esd_pkg::CH_NUL);
    assign c_octal = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
    assign c_digit = c[2:0];

    // Close of an octal run: exact 0 and 92 expand to two bytes
    assign fo_special = !ovf_reg && ((oval_reg == esd_pkg::CH_NUL) || (oval_reg == esd_pkg::CH_BSL));
    assign fo_b0 = fo_special ? esd_pkg::CH_BSL : oval_reg;
    assign fo_b1 = (oval_reg != esd_pkg::CH_NUL) ? esd_pkg::CH_BSL : esd_pkg::CH_UP_N;

    always_comb
    begin
        mode_next   = mode_reg;
        oval_next   = oval_reg;
        ovf_next    = ovf_reg;
        raw_vld     = 3'b000;
        raw_byte[0] = c;
        raw_byte[1] = c;
        raw_byte[2] = c;
        term        = 1'b0;

        if (is_end)
        begin
            if (mode_reg == MODE_OCTAL)
            begin
                raw_vld[0]  = 1'b1;
                raw_byte[0] = fo_b0;
                raw_vld[1]  = fo_special;
                raw_byte[1] = fo_b1;
            end
            term      = 1'b1;
            mode_next = MODE_NORMAL;
            oval_next = esd_pkg::CH_NUL;
            ovf_next  = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_CARET:
                begin
                    mode_next   = MODE_NORMAL;
                    raw_vld[0]  = 1'b1;
                    raw_byte[0] = c & esd_pkg::CARET_MASK;
                end
                MODE_BSLASH:
                begin
                    mode_next = MODE_NORMAL;
                    case (c)
                        esd_pkg::CH_LF: ;
                        esd_pkg::CH_LO_R:
                        begin
                            raw_vld[0]  = 1'b1;
                            raw_byte[0] = esd_pkg::CH_CR;
                        end
                        esd_pkg::CH_LO_N:
                        begin
                            raw_vld[0]  = 1'b1;
                            raw_byte[0] = esd_pkg::CH_LF;
                        end
                        esd_pkg::CH_LO_B:
                        begin
                            raw_vld[0]  = 1'b1;
                            raw_byte[0] = esd_pkg::CH_BS;
                        end
                        esd_pkg::CH_LO_S:
                        begin
                            raw_vld[0]  = 1'b1;
                            raw_byte[0] = esd_pkg::CH_SPACE;
                        end
                        esd_pkg::CH_LO_T:
                        begin
                            raw_vld[0]  = 1'b1;
                            raw_byte[0] = esd_pkg::CH_TAB;
                        end
                        esd_pkg::CH_MINUS:
                        begin
                            raw_vld[1:0] = 2'b11;
                            raw_byte[0]  = esd_pkg::CH_BSL;
                        end
                        esd_pkg::CH_BSL, esd_pkg::CH_LO_D, esd_pkg::CH_LO_P,
                        esd_pkg::CH_LO_L, esd_pkg::CH_LO_C, esd_pkg::CH_UP_K:
                        begin
                            // keep doubled in send mode, otherwise stands for itself
                            raw_vld[0] = 1'b1;
                            if (send_mode_reg)
                            begin
                                raw_vld[1]  = 1'b1;
                                raw_byte[0] = esd_pkg::CH_BSL;
                            end
                        end
                        default:
                        begin
                            if (c_octal)
                            begin
                                oval_next = {5'd0, c_digit};
                                ovf_next  = 1'b0;
                                mode_next = MODE_OCTAL;
                            end
                            else
                            begin
                                raw_vld[0] = 1'b1;
                            end
                        end
                    endcase
                end
                MODE_OCTAL:
                begin
                    if (c_octal)
                    begin
                        oval_next = {oval_reg[4:0], c_digit};
                        ovf_next  = ovf_reg || (oval_reg[7:5] != 3'd0);
                    end
                    else
                    begin
                        raw_vld[0]  = 1'b1;
                        raw_byte[0] = fo_b0;
                        raw_vld[1]  = fo_special;
                        raw_byte[1] = fo_b1;
                        oval_next   = esd_pkg::CH_NUL;
                        ovf_next    = 1'b0;
                        mode_next   = MODE_NORMAL;
                        if (c == esd_pkg::CH_CARET)
                        begin
                            mode_next = MODE_CARET;
                        end
                        else if (c == esd_pkg::CH_BSL)
                        begin
                            mode_next = MODE_BSLASH;
                        end
                        else if (c != esd_pkg::CH_QUOTE)
                        begin
                            raw_vld[2] = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (c == esd_pkg::CH_CARET)
                    begin
                        mode_next = MODE_CARET;
                    end
                    else if (c == esd_pkg::CH_BSL)
                    begin
                        mode_next = MODE_BSLASH;
                    end
                    else if (c != esd_pkg::CH_QUOTE)
                    begin
                        raw_vld[0] = 1'b1;
                    end
                end
            endcase
        end
    end

    // Drop bytes after a produced zero, pack survivors into slots, append the end marker
    always_comb
    begin
        sup  = sup_reg;
        kcnt = 2'd0;
        bnd  = '0;
        for (int k = 0; k < esd_pkg::SLOTS; k++)
        begin
            if (raw_vld[k] && !sup)
            begin
                if (raw_byte[k] == esd_pkg::CH_NUL)
                begin
                    sup = 1'b1;
                end
                else
                begin
                    bnd.slots[kcnt].data       = raw_byte[k];
                    bnd.slots[kcnt].string_end = 1'b0;
                    kcnt = kcnt + 2'd1;
                end
            end
        end
        if (term)
        begin
            bnd.slots[kcnt].data       = esd_pkg::CH_NUL;
            bnd.slots[kcnt].string_end = 1'b1;
            kcnt = kcnt + 2'd1;
        end
        bnd.cnt  = kcnt;
        sup_next = term ? 1'b0 : sup;
    end

    assign bundle      = bnd;
    assign bundle_push = in_fire && (bnd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            oval_reg      <= 8'd0;
            ovf_reg       <= 1'b0;
            sup_reg       <= 1'b0;
            send_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                send_mode_reg <= cfg_data;
            end
            if (in_fire)
            begin
                mode_reg <= mode_next;
                oval_reg <= oval_next;
                ovf_reg  <= ovf_next;
                sup_reg  <= sup_next;
            end
        end
    end

endmodule

### design/esd_queue.sv
// Bundle queue between the parser and the result serializer.
module esd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  esd_pkg::bundle_t wr_bundle,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output esd_pkg::bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    esd_pkg::bundle_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/esd_back.sv
// Back end: walks the head bundle and presents one result per transfer.
module esd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  esd_pkg::bundle_t   head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output esd_pkg::out_item_t out_data
);

    logic [1:0]    idx_reg, idx_next;
    logic          last;
    esd_pkg::slot_t cur;

    assign cur   = head.slots[idx_reg];
    assign last  = (idx_reg == (head.cnt - 2'd1));
    assign empty = q_empty;
    assign q_pop = pop && !q_empty && last;

    assign out_data.out_byte    = cur.data;
    assign out_data.string_end  = cur.string_end;
    assign out_data.last_of_run = last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop && !q_empty)
        begin
            // advance within the bundle, wrap when its last result leaves
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### design/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: parser, bundle queue, serializer.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------
//  input    | push / full       | in_data  (kind, in_byte)
//  result   | empty / pop       | out_data (out_byte, string_end, last_of_run)
//  config   | cfg_we            | cfg_data (send_mode)
//
// One input item is taken per cycle while the queue has room; the parser
// handles it in that cycle and enqueues its results (up to three) as one bundle.
// The result side presents one result per cycle while pop is high and results wait, so an
// item's results leave the serializer one by one; DEPTH bundles buffer the two sides.
// Reset clears the parse state, send_mode and the queue pointers.
module escape_sequence_decoder #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               push,
    input  esd_pkg::in_item_t  in_data,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output esd_pkg::out_item_t out_data
);

    logic             in_fire;
    logic             bundle_push;
    esd_pkg::bundle_t bundle;
    esd_pkg::bundle_t head;
    logic             q_empty;
    logic             q_pop;

    assign in_fire = push && !full;

    esd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .in_item     (in_data),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    esd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle_push),
        .wr_bundle (bundle),
        .full      (full),
        .empty     (q_empty),
        .pop       (q_pop),
        .head      (head)
    );

    esd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

endmodule

### test/tb_escape_sequence_decoder.sv
// Self-checking testbench for the escape sequence decoder with a built-in string predictor.
module tb_escape_sequence_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS    = 344;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_LIMIT    = 10;

    typedef enum logic [1:0] {PS_PLAIN, PS_CARET, PS_ESC, PS_OCT} scan_t;
    typedef enum logic {ROW_ITEM, ROW_MODE} row_op_t;

    // ROW_MODE rows write send_mode from ch[0]; ROW_ITEM rows with typed set
    // carry their own expected results instead of the predictor's.
    typedef struct packed {
        row_op_t            op;
        logic               kind;
        logic [7:0]         ch;
        logic               typed;
        logic [1:0]         n_exp;
        esd_pkg::out_item_t e0;
        esd_pkg::out_item_t e1;
        esd_pkg::out_item_t e2;
    } row_t;

    localparam esd_pkg::out_item_t NONE = '0;
    localparam esd_pkg::out_item_t TERM = {esd_pkg::CH_NUL, 1'b1, 1'b1};

    localparam int N_DIR = 29;
    localparam row_t DIRECTED [N_DIR] = '{
        '{ROW_MODE, 1'b0, 8'h00,             1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b1, 8'hff,             1'b1, 2'd1, TERM, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_CARET, 1'b1, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, 8'hff,             1'b1, 2'd1, {8'h1f, 1'b0, 1'b1}, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_QUOTE, 1'b1, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_LO_T,  1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_MINUS, 1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_LF,    1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, "1",               1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, "3",               1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, "4",               1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, "x",               1'b1, 2'd3, {esd_pkg::CH_BSL, 1'b0, 1'b0},
          {esd_pkg::CH_BSL, 1'b0, 1'b0}, {8'h78, 1'b0, 1'b1}},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_ZERO,  1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_NUL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_CARET, 1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b1, esd_pkg::CH_NUL,   1'b1, 2'd1, TERM, NONE, NONE},
        '{ROW_MODE, 1'b0, 8'h01,             1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_LO_D,  1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_BSL,   1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, "4",               1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_ZERO,  1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b0, esd_pkg::CH_ZERO,  1'b0, 2'd0, NONE, NONE, NONE},
        '{ROW_ITEM, 1'b1, 8'h55,             1'b1, 2'd1, TERM, NONE, NONE}
    };

    localparam logic [7:0] ESC_KEYS [13] = '{
        esd_pkg::CH_LO_R, esd_pkg::CH_LO_N, esd_pkg::CH_LO_B, esd_pkg::CH_LO_S,
        esd_pkg::CH_LO_T, esd_pkg::CH_LF, esd_pkg::CH_MINUS, esd_pkg::CH_BSL,
        esd_pkg::CH_LO_D, esd_pkg::CH_LO_P, esd_pkg::CH_LO_L, esd_pkg::CH_LO_C,
        esd_pkg::CH_UP_K};
    // exact 92, exact 0, wrapped 0 and wrapped 92
    localparam string OCT_RUNS [4] = '{"134", "000", "400", "534"};

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic               cfg_data = 1'b0;
    logic               push     = 1'b0;
    esd_pkg::in_item_t  in_data  = '0;
    logic               full;
    logic               empty;
    logic               pop      = 1'b0;
    esd_pkg::out_item_t out_data;

    // predictor state
    scan_t              scan         = PS_PLAIN;
    logic [7:0]         oct_acc      = '0;
    logic               oct_wrapped  = 1'b0;
    logic               muted        = 1'b0;
    logic               keep_doubled = 1'b0;
    esd_pkg::out_item_t burst [$];
    esd_pkg::out_item_t decoded_q [$];

    int  items_sent   = 0;
    int  results_seen = 0;
    int  strings_done = 0;
    int  fails        = 0;
    int  full_cycles  = 0;
    int  tx_quiet     = 0;
    int  rx_quiet     = 0;
    bit  hold_req     = 1'b0;
    bit  hold_on      = 1'b0;

    escape_sequence_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .in_data  (in_data),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (push && full)
            full_cycles++;
    end

    function automatic bit is_oct(input logic [7:0] c);
        return c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_SEVEN;
    endfunction

    // A produced zero byte mutes the rest of the string.
    task automatic put_char(input logic [7:0] b);
        esd_pkg::out_item_t r;
        if (muted)
            return;
        if (b == esd_pkg::CH_NUL)
        begin
            muted = 1'b1;
            return;
        end
        r.out_byte    = b;
        r.string_end  = 1'b0;
        r.last_of_run = 1'b0;
        burst.push_back(r);
    endtask

    task automatic flush_octal();
        if (!oct_wrapped && (oct_acc == esd_pkg::CH_NUL || oct_acc == esd_pkg::CH_BSL))
        begin
            put_char(esd_pkg::CH_BSL);
            put_char(oct_acc == esd_pkg::CH_NUL ? esd_pkg::CH_UP_N : esd_pkg::CH_BSL);
        end
        else
            put_char(oct_acc);
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == esd_pkg::CH_CARET)
            scan = PS_CARET;
        else if (c == esd_pkg::CH_BSL)
            scan = PS_ESC;
        else if (c != esd_pkg::CH_QUOTE)
            put_char(c);
    endtask

    task automatic take_escaped(input logic [7:0] c);
        scan = PS_PLAIN;
        case (c)
            esd_pkg::CH_LF:   return;
            esd_pkg::CH_LO_R: begin put_char(esd_pkg::CH_CR);    return; end
            esd_pkg::CH_LO_N: begin put_char(esd_pkg::CH_LF);    return; end
            esd_pkg::CH_LO_B: begin put_char(esd_pkg::CH_BS);    return; end
            esd_pkg::CH_LO_S: begin put_char(esd_pkg::CH_SPACE); return; end
            esd_pkg::CH_LO_T: begin put_char(esd_pkg::CH_TAB);   return; end
            esd_pkg::CH_MINUS:
            begin
                put_char(esd_pkg::CH_BSL);
                put_char(c);
                return;
            end
            esd_pkg::CH_BSL, esd_pkg::CH_LO_D, esd_pkg::CH_LO_P, esd_pkg::CH_LO_L,
            esd_pkg::CH_LO_C, esd_pkg::CH_UP_K:
            begin
                if (keep_doubled)
                begin
                    put_char(esd_pkg::CH_BSL);
                    put_char(c);
                    return;
                end
            end
            default: ;
        endcase
        if (is_oct(c))
        begin
            oct_acc     = c - esd_pkg::CH_ZERO;
            oct_wrapped = 1'b0;
            scan        = PS_OCT;
        end
        else
            put_char(c);
    endtask

    // Fill burst with the results one accepted item causes.
    task automatic decode_item(input esd_pkg::in_item_t it);
        logic [10:0]        acc;
        esd_pkg::out_item_t term;
        burst.delete();
        if (it.kind || it.in_byte == esd_pkg::CH_NUL)
        begin
            if (scan == PS_OCT)
                flush_octal();
            term.out_byte    = esd_pkg::CH_NUL;
            term.string_end  = 1'b1;
            term.last_of_run = 1'b0;
            burst.push_back(term);
            scan        = PS_PLAIN;
            oct_acc     = '0;
            oct_wrapped = 1'b0;
            muted       = 1'b0;
        end
        else
        begin
            case (scan)
                PS_CARET:
                begin
                    scan = PS_PLAIN;
                    put_char(it.in_byte & esd_pkg::CARET_MASK);
                end
                PS_ESC: take_escaped(it.in_byte);
                PS_OCT:
                begin
                    if (is_oct(it.in_byte))
                    begin
                        acc = {3'b000, oct_acc} * 11'd8
                            + {3'b000, it.in_byte - esd_pkg::CH_ZERO};
                        if (acc > 11'd255)
                            oct_wrapped = 1'b1;
                        oct_acc = acc[7:0];
                    end
                    else
                    begin
                        flush_octal();
                        scan        = PS_PLAIN;
                        oct_acc     = '0;
                        oct_wrapped = 1'b0;
                        take_plain(it.in_byte);
                    end
                end
                default: take_plain(it.in_byte);
            endcase
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last_of_run = 1'b1;
    endtask

    function automatic int draw_gap(inout int quiet);
        if (hold_on)
            return 0;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= SHOW_LIMIT)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic send_item(input esd_pkg::in_item_t it, input logic typed,
                             input logic [1:0] n_typed, input esd_pkg::out_item_t e0,
                             input esd_pkg::out_item_t e1, input esd_pkg::out_item_t e2);
        int                 gap;
        esd_pkg::out_item_t hand [3];
        gap = draw_gap(tx_quiet);
        // keep push high across back-to-back transfers
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (full);
        items_sent++;
        decode_item(it);
        if (typed)
        begin
            hand = '{e0, e1, e2};
            for (int k = 0; k < n_typed; k++)
                decoded_q.push_back(hand[k]);
        end
        else
        begin
            foreach (burst[k])
                decoded_q.push_back(burst[k]);
        end
    endtask

    task automatic send_raw(input logic kind, input logic [7:0] b);
        esd_pkg::in_item_t it;
        it.kind    = kind;
        it.in_byte = b;
        send_item(it, 1'b0, 2'd0, NONE, NONE, NONE);
    endtask

    // Drop push, wait for every expected result, then let the pipeline drain.
    task automatic settle();
        push <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        keep_doubled = v;
    endtask

    // One well-formed fragment of a script string, or a bit of noise.
    task automatic send_token();
        int    pick;
        int    len;
        string run;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            send_raw(1'b0, 8'($urandom_range(1, 255)));
        else if (pick < 38)
        begin
            send_raw(1'b0, esd_pkg::CH_CARET);
            send_raw(1'b0, 8'($urandom_range(0, 255)));
        end
        else if (pick < 60)
        begin
            send_raw(1'b0, esd_pkg::CH_BSL);
            if ($urandom_range(0, 3) != 0)
                send_raw(1'b0, ESC_KEYS[$urandom_range(0, 12)]);
            else
                send_raw(1'b0, 8'($urandom_range(0, 255)));
        end
        else if (pick < 76)
        begin
            send_raw(1'b0, esd_pkg::CH_BSL);
            if ($urandom_range(0, 3) == 0)
            begin
                run = OCT_RUNS[$urandom_range(0, 3)];
                for (int k = 0; k < run.len(); k++)
                    send_raw(1'b0, 8'(run[k]));
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    send_raw(1'b0, esd_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
            end
        end
        else if (pick < 82)
            send_raw(1'b0, esd_pkg::CH_QUOTE);
        else if (pick < 90)
        begin
            // sometimes leave an escape dangling at the end of the string
            if ($urandom_range(0, 2) == 0)
                send_raw(1'b0, $urandom_range(0, 1) ? esd_pkg::CH_CARET : esd_pkg::CH_BSL);
            if ($urandom_range(0, 1) != 0)
                send_raw(1'b1, 8'($urandom_range(0, 255)));
            else
                send_raw(1'b0, esd_pkg::CH_NUL);
        end
        else
            send_raw(1'(($urandom_range(0, 1))), 8'($urandom_range(0, 255)));
    endtask

    task automatic check_result(input esd_pkg::out_item_t got);
        esd_pkg::out_item_t want;
        results_seen++;
        if (decoded_q.size() == 0)
        begin
            note_fail($sformatf("unexpected result: byte %02h end %0b last %0b",
                                got.out_byte, got.string_end, got.last_of_run));
            return;
        end
        want = decoded_q.pop_front();
        if (got.string_end === 1'b1)
            strings_done++;
        if (got.out_byte !== want.out_byte || got.string_end !== want.string_end ||
            got.last_of_run !== want.last_of_run)
            note_fail($sformatf({"result %0d: expected byte %02h end %0b last %0b, ",
                                 "got byte %02h end %0b last %0b"},
                                results_seen, want.out_byte, want.string_end, want.last_of_run,
                                got.out_byte, got.string_end, got.last_of_run));
    endtask

    // result side
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                // hold off long enough for the block to fill and stall its input
                pop     <= 1'b0;
                hold_on  = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on  = 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                gap = draw_gap(rx_quiet);
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            check_result(out_data);
        end
    end

    // input side and run control
    initial
    begin
        int goal;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIRECTED[i].op == ROW_MODE)
            begin
                settle();
                write_mode(DIRECTED[i].ch[0]);
            end
            else
                send_item('{kind: DIRECTED[i].kind, in_byte: DIRECTED[i].ch}, DIRECTED[i].typed,
                          DIRECTED[i].n_exp, DIRECTED[i].e0, DIRECTED[i].e1, DIRECTED[i].e2);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            write_mode((ph % 2) == 0);
            if (ph == 1)
                hold_req = 1'b1;
            goal = items_sent + RAND_ITEMS / 4;
            while (items_sent < goal)
                send_token();
        end
        settle();

        $display("Run covered %0d input items, %0d results and %0d strings in both send modes.",
                 items_sent, results_seen, strings_done);
        $display("Input saw full for %0d cycles, including a %0d-cycle hold on the result side.",
                 full_cycles, HOLD_CYCLES);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #600_000;
        $display("Timeout with %0d results still expected.", decoded_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
design/esd_pkg.sv
design/esd_front.sv
design/esd_queue.sv
design/esd_back.sv
design/escape_sequence_decoder.sv
test/tb_escape_sequence_decoder.sv
